[hdl/pkcrc_pkg.sv]
// shared types, constants and crc helper for the packet crc16 seal and check block
package pkcrc_pkg;

    localparam int MAX_PACKET_BYTES = 4096;
    localparam int COUNT_W          = $clog2(MAX_PACKET_BYTES + 2);
    localparam logic [15:0] POLY_RESET = 16'h1021;
    localparam logic [15:0] CRC_TOP_BIT = 16'h8000;

    localparam int PUSH_MAX   = 3;
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FILL_W     = PTR_W + 1;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_POLY = 1'b0;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_SHORT    = 2'd2,
        ST_LONG     = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_crc_byte;
        logic       end_of_packet;
        status_t    status;
    } result_t;

    // one byte through the crc, msb first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc,
                                             input logic [7:0]  b,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP_BIT) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ poly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[hdl/pkcrc_result_fifo.sv]
// result queue taking up to three results per beat and releasing one per beat while out_ready is high
module pkcrc_result_fifo (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [1:0]                          push_cnt,
    input  pkcrc_pkg::result_t                  push_data [pkcrc_pkg::PUSH_MAX],
    output logic                                space_ok,
    output logic                                out_valid,
    input  logic                                out_ready,
    output pkcrc_pkg::result_t                  out_data
);
    import pkcrc_pkg::*;

    result_t           mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              pop;

    assign out_valid = (fill_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // room for a full end-of-packet burst regardless of the pop this cycle
    assign space_ok  = (fill_reg <= FILL_W'(FIFO_DEPTH - PUSH_MAX));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        fill_next   = fill_reg + FILL_W'(push_cnt) - FILL_W'(pop);
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < PUSH_MAX; k++) begin
            if (2'(k) < push_cnt) begin
                mem[wr_ptr_reg + PTR_W'(k)] <= push_data[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

[hdl/packet_crc16_seal_and_check_top.sv]
// top level of the packet crc16 seal and check block
//
//  channel   direction  tdata          tuser                      tlast
//  s_        in         data_byte      operation                  last_byte
//  m_        out        out_byte       is_crc_byte, status        end_of_packet
//  apb       in/out     crc_polynomial at byte address 0
//
// one input beat per cycle; the byte crc update is combinational xor logic
// feeding an eight-entry result queue. a packet end pushes up to three results,
// so s_tready drops while the queue holds more than five, otherwise the input
// keeps flowing while results wait on m_tready. synchronous active-low reset
// clears the packet state, the queue and sets the polynomial to 0x1021.
module packet_crc16_seal_and_check_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] data_byte
    input  logic                               s_tlast,   // last_byte
    input  logic                               s_tuser,   // [0] operation
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // [7:0] out_byte
    output logic                               m_tlast,   // end_of_packet
    output logic [2:0]                         m_tuser,   // [0] is_crc_byte, [2:1] status
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pkcrc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pkcrc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pkcrc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                               pready
);
    import pkcrc_pkg::*;

    logic [15:0]        poly_reg;
    logic [15:0]        crc_reg, crc_next;
    logic [7:0]         older_reg, older_next;
    logic [7:0]         newer_reg, newer_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               op_reg, op_next;

    logic               accept;
    logic               cur_op;
    logic [15:0]        crc_fed;
    logic [COUNT_W-1:0] count_inc;
    logic               pay_valid;
    result_t            pay_res, end_res0, end_res1;
    logic [1:0]         end_cnt;
    logic [1:0]         push_cnt;
    result_t            push_data [PUSH_MAX];
    logic               space_ok;
    result_t            out_res;
    logic               cfg_wr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_POLY);
    assign prdata = (paddr[2] == REG_POLY) ? APB_DATA_W'(poly_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg <= POLY_RESET;
        end else if (cfg_wr) begin
            poly_reg <= pwdata[15:0];
        end
    end

    assign s_tready = space_ok;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cur_op    = (count_reg == '0) ? s_tuser : op_reg;
        // older held byte becomes payload once two newer beats have arrived
        pay_valid = 1'b0;
        crc_fed   = crc_reg;
        if (count_reg >= COUNT_W'(2)) begin
            crc_fed   = crc_feed(crc_reg, older_reg, poly_reg);
            pay_valid = cur_op;
        end
        count_inc = (count_reg < COUNT_W'(MAX_PACKET_BYTES + 1)) ?
                    count_reg + COUNT_W'(1) : count_reg;

        pay_res  = '{out_byte: older_reg, is_crc_byte: 1'b0,
                     end_of_packet: 1'b0, status: ST_OK};
        end_res0 = '{out_byte: 8'h00, is_crc_byte: 1'b0,
                     end_of_packet: 1'b1, status: ST_SHORT};
        end_res1 = end_res0;
        end_cnt  = 2'd0;
        if (s_tlast) begin
            if (count_inc < COUNT_W'(2)) begin
                end_cnt = 2'd1;
            end else if (cur_op) begin
                end_cnt  = 2'd2;
                end_res0 = '{out_byte: crc_fed[7:0], is_crc_byte: 1'b1,
                             end_of_packet: 1'b0, status: ST_OK};
                end_res1 = '{out_byte: crc_fed[15:8], is_crc_byte: 1'b1,
                             end_of_packet: 1'b1,
                             status: (count_inc > COUNT_W'(MAX_PACKET_BYTES)) ?
                                     ST_LONG : ST_OK};
            end else begin
                // trailer is little endian: newest byte is the high half
                end_cnt  = 2'd1;
                end_res0 = '{out_byte: 8'h00, is_crc_byte: 1'b0,
                             end_of_packet: 1'b1,
                             status: ({s_tdata, newer_reg} == crc_fed) ?
                                     ST_OK : ST_MISMATCH};
            end
        end

        if (pay_valid) begin
            push_data[0] = pay_res;
            push_data[1] = end_res0;
            push_data[2] = end_res1;
        end else begin
            push_data[0] = end_res0;
            push_data[1] = end_res1;
            push_data[2] = end_res1;
        end
        push_cnt = accept ? (end_cnt + 2'(pay_valid)) : 2'd0;

        crc_next   = crc_reg;
        older_next = older_reg;
        newer_next = newer_reg;
        count_next = count_reg;
        op_next    = op_reg;
        if (accept) begin
            if (s_tlast) begin
                crc_next   = '0;
                older_next = '0;
                newer_next = '0;
                count_next = '0;
                op_next    = 1'b0;
            end else begin
                crc_next   = crc_fed;
                older_next = newer_reg;
                newer_next = s_tdata;
                count_next = count_inc;
                op_next    = cur_op;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= '0;
            older_reg <= '0;
            newer_reg <= '0;
            count_reg <= '0;
            op_reg    <= 1'b0;
        end else begin
            crc_reg   <= crc_next;
            older_reg <= older_next;
            newer_reg <= newer_next;
            count_reg <= count_next;
            op_reg    <= op_next;
        end
    end

    pkcrc_result_fifo u_result_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .push_data (push_data),
        .space_ok  (space_ok),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = out_res.out_byte;
    assign m_tlast = out_res.end_of_packet;
    assign m_tuser = {out_res.status, out_res.is_crc_byte};

endmodule

[test/tb_top.sv]
// self-checking testbench for the packet crc16 seal and check block
module tb_top;

    import pkcrc_pkg::*;

    localparam logic OP_CHECK = 1'b0;
    localparam logic OP_SEAL  = 1'b1;
    localparam logic [APB_ADDR_W-1:0] POLY_ADDR = {REG_POLY, 2'b00};
    localparam int PHASE_ITEMS   = 115;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 600000;

    typedef logic [7:0] byte_q_t[$];

    // predicts the result beats of the block and holds them until they arrive
    class crc_seal_scoreboard;
        logic [15:0] poly;
        logic [15:0] crc_acc;
        logic [7:0]  older_byte;
        logic [7:0]  newer_byte;
        logic [12:0] seen_count;
        logic        pkt_op;
        result_t     due_q[$];
        int          errors;

        function new();
            poly   = POLY_RESET;
            errors = 0;
            clear();
        endfunction

        function void clear();
            crc_acc    = '0;
            older_byte = '0;
            newer_byte = '0;
            seen_count = '0;
            pkt_op     = OP_CHECK;
        endfunction

        function logic [15:0] feed(logic [15:0] crc, logic [7:0] b);
            logic [15:0] c;
            c = crc ^ {b, 8'h00};
            for (int i = 0; i < 8; i++) begin
                if (c[15]) begin
                    c = {c[14:0], 1'b0} ^ poly;
                end else begin
                    c = {c[14:0], 1'b0};
                end
            end
            return c;
        endfunction

        function logic [15:0] crc_over(byte_q_t bytes);
            logic [15:0] c;
            c = '0;
            foreach (bytes[i]) c = feed(c, bytes[i]);
            return c;
        endfunction

        function void push(logic [7:0] b, logic crc_flag, logic eop, status_t st);
            result_t r;
            r.out_byte      = b;
            r.is_crc_byte   = crc_flag;
            r.end_of_packet = eop;
            r.status        = st;
            due_q.push_back(r);
        endfunction

        function void note_byte(logic op, logic [7:0] b, logic last);
            if (seen_count == 0) pkt_op = op;
            // a byte is payload only once two newer bytes are behind it
            if (seen_count >= 2) begin
                crc_acc = feed(crc_acc, older_byte);
                if (pkt_op == OP_SEAL) push(older_byte, 1'b0, 1'b0, ST_OK);
            end
            older_byte = newer_byte;
            newer_byte = b;
            if (seen_count < 13'(MAX_PACKET_BYTES + 1)) seen_count++;
            if (!last) return;
            if (seen_count < 2) begin
                push(8'h00, 1'b0, 1'b1, ST_SHORT);
            end else if (pkt_op == OP_SEAL) begin
                push(crc_acc[7:0], 1'b1, 1'b0, ST_OK);
                push(crc_acc[15:8], 1'b1, 1'b1,
                     (seen_count > 13'(MAX_PACKET_BYTES)) ? ST_LONG : ST_OK);
            end else begin
                push(8'h00, 1'b0, 1'b1,
                     ({newer_byte, older_byte} == crc_acc) ? ST_OK : ST_MISMATCH);
            end
            clear();
        endfunction

        function void check_beat(logic [7:0] d, logic crc_flag, logic eop, logic [1:0] st);
            result_t want;
            if (due_q.size() == 0) begin
                $error("result beat with nothing expected: out_byte %0d", d);
                errors++;
                return;
            end
            want = due_q.pop_front();
            if (want.out_byte !== d) begin
                $error("out_byte: expected %0d, got %0d", want.out_byte, d);
                errors++;
            end
            if (want.is_crc_byte !== crc_flag) begin
                $error("is_crc_byte: expected %0d, got %0d", want.is_crc_byte, crc_flag);
                errors++;
            end
            if (want.end_of_packet !== eop) begin
                $error("end_of_packet: expected %0d, got %0d", want.end_of_packet, eop);
                errors++;
            end
            if (want.status !== st) begin
                $error("status: expected %0d, got %0d", want.status, st);
                errors++;
            end
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tlast;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;
    logic                  m_tlast;
    logic [2:0]            m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    crc_seal_scoreboard sb;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int sent_items    = 0;
    int cycles        = 0;

    packet_crc16_seal_and_check_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_beat(m_tdata, m_tuser[0], m_tlast, m_tuser[2:1]);
        end
    end

    task automatic send_byte(input logic op, input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(op, b, last);
        sent_items++;
    endtask

    // later bytes may carry a different operation when loose_op is set
    task automatic send_packet(input logic op, input byte_q_t body, input bit add_trailer,
                               input bit loose_op);
        logic [15:0] crc;
        logic        bop;
        if (add_trailer) begin
            crc = sb.crc_over(body);
            body.push_back(crc[7:0]);
            body.push_back(crc[15:8]);
        end
        foreach (body[i]) begin
            bop = (i == 0 || !loose_op) ? op : 1'($urandom);
            send_byte(bop, body[i], i == body.size() - 1);
        end
    endtask

    function automatic byte_q_t random_body(int len);
        byte_q_t q;
        for (int i = 0; i < len; i++) q.push_back(8'($urandom));
        return q;
    endfunction

    task automatic send_random_packet();
        int   len;
        logic op;
        bit   trailer;
        bit   loose;
        len     = ($urandom_range(99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 48);
        op      = 1'($urandom);
        trailer = (op == OP_CHECK) && ($urandom_range(99) < 75);
        loose   = ($urandom_range(99) < 15);
        send_packet(op, random_body(len), trailer, loose);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // write then read back over back-to-back apb transfers
    task automatic write_poly(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= POLY_ADDR;
        pwdata  <= {16'h0000, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.poly = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[15:0] !== value) begin
            $error("crc_polynomial: expected %0h, got %0h", value, prdata[15:0]);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        logic [15:0] crc;
        logic [15:0] phase_poly[4];
        int          phase_idle[4];
        int          phase_stall[4];
        int          start_items;
        bit          paused;

        sb = new();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        s_tuser  <= 1'b0;
        m_tready <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed packets at the reset polynomial
        send_packet(OP_CHECK, '{8'h00}, 1'b0, 1'b0);
        send_packet(OP_SEAL, '{8'hFF}, 1'b0, 1'b0);
        send_packet(OP_CHECK, '{8'h00, 8'h00}, 1'b0, 1'b0);
        send_packet(OP_CHECK, '{8'hFF, 8'hFF}, 1'b0, 1'b0);
        send_packet(OP_SEAL, '{8'hA5, 8'h5A}, 1'b0, 1'b0);
        send_packet(OP_SEAL, '{8'h00, 8'hFF, 8'h80, 8'h01}, 1'b1, 1'b0);
        send_packet(OP_CHECK, '{8'h00, 8'hFF, 8'h80, 8'h01}, 1'b1, 1'b0);
        send_packet(OP_CHECK, '{8'h5A, 8'h12, 8'h34}, 1'b0, 1'b0);
        // operation flips after the first byte and must be ignored
        crc = sb.crc_over('{8'h7F});
        send_byte(OP_CHECK, 8'h7F, 1'b0);
        send_byte(OP_SEAL, crc[7:0], 1'b0);
        send_byte(OP_SEAL, crc[15:8], 1'b1);
        wait_drained();

        phase_poly  = '{16'h0000, 16'hFFFF, 16'($urandom), 16'h8005};
        phase_idle  = '{0, 79, 0, 33};
        phase_stall = '{0, 0, 79, 33};
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = phase_idle[p];
            stall_pct     = phase_stall[p];
            write_poly(phase_poly[p]);
            start_items = sent_items;
            paused      = 1'b0;
            while (sent_items - start_items < PHASE_ITEMS) begin
                send_random_packet();
                if (p == 1 && !paused && sent_items - start_items > PHASE_ITEMS / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
            wait_drained();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
